### rtl/swm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_pkg
// Shared widths, defaults and compare-unit codes for the sliding window max.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int WINDOW_MAX_DEF = 64;
	localparam int SAMPLE_W       = 16;
	localparam int WLEN_W         = 7;

	localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(1);

	// operation of the shared compare unit
	typedef enum logic [1:0] {
		CMP_AGE = 2'b01,	// front entry age >= window length
		CMP_VAL = 2'b10		// new sample > rear entry value
	} cmp_mode_t;

endpackage
`default_nettype wire

### rtl/swm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_if
// Valid/ready channels for samples in and window results out.
// ----------------------------------------------------------------------------
interface swm_sample_if import swm_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_value;
	logic                       last_sample;

	modport source (output valid, output sample_value, output last_sample, input ready);
	modport sink   (input valid, input sample_value, input last_sample, output ready);
endinterface

interface swm_result_if import swm_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] window_max;
	logic                       is_last;

	modport source (output valid, output window_max, output is_last, input ready);
	modport sink   (input valid, input window_max, input is_last, output ready);
endinterface
`default_nettype wire

### rtl/swm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/swm_cmp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_cmp
// Shared compare unit: front age check or rear value check, one per cycle.
// ----------------------------------------------------------------------------
module swm_cmp import swm_pkg::*; #(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
	input  wire cmp_mode_t                                    mode,
	input  wire logic [$clog2(2*WINDOW_MAX)-1:0]              pos,
	input  wire logic [$clog2(2*WINDOW_MAX)-1:0]              rd_pos,
	input  wire logic [(($clog2(WINDOW_MAX+1) > WLEN_W) ?
	                    $clog2(WINDOW_MAX+1) : WLEN_W)-1:0]   eff,
	input  wire logic signed [SAMPLE_W-1:0]                   sample,
	input  wire logic signed [SAMPLE_W-1:0]                   rd_val,
	output logic                                              hit
);

	localparam int POS_W   = $clog2(2*WINDOW_MAX);
	localparam int POS_MOD = 2*WINDOW_MAX;
	localparam int CNT_W   = $clog2(WINDOW_MAX+1);
	localparam int EFF_W   = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
	localparam int MAX_A   = (SAMPLE_W > POS_W) ? SAMPLE_W : POS_W;
	localparam int OP_W    = ((MAX_A > EFF_W) ? MAX_A : EFF_W) + 1;

	logic        [POS_W:0]  diff;
	logic        [POS_W-1:0] age;
	logic signed [OP_W-1:0] op_a;
	logic signed [OP_W-1:0] op_b;

	// modular age of the entry, positions wrap at twice the window depth
	assign diff = {1'b0, pos} - {1'b0, rd_pos};
	assign age  = diff[POS_W] ? POS_W'(diff + (POS_W+1)'(POS_MOD)) : diff[POS_W-1:0];

	always_comb begin
		case (mode)
			CMP_AGE: begin
				op_a = OP_W'(age);
				op_b = OP_W'(eff);
			end
			CMP_VAL: begin
				op_a = OP_W'(sample);
				op_b = OP_W'(rd_val);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// age: drop when age >= eff; value: pop when sample > rear
	assign hit = (op_a > op_b) || ((mode == CMP_AGE) && (op_a == op_b));

endmodule
`default_nettype wire

### rtl/sliding_window_maximum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_maximum
// Streaming maximum over the latest window_len signed samples, using a
// monotonic deque of (value, position) candidates kept in one RAM.
// ----------------------------------------------------------------------------
//
//  channel      dir  handshake          payload
//  -----------  ---  -----------------  ----------------------------------
//  samples      in   valid / ready      sample_value[15:0], last_sample
//  results      out  valid / ready      window_max[15:0], is_last
//  window_len   in   window_len_we      window_len[6:0]
//
//  Steps: a request goes straight to the push when the deque is empty.
//  Otherwise the front sweep drops expired front entries, the rear sweep
//  pops smaller rear entries, and the push writes the sample. Each entry
//  leaves the deque once. The single RAM read port sets the pace: one
//  candidate is looked at per cycle through the shared compare unit.
//  Reset: control state, pointers and counters clear; the candidate RAM is
//  not cleared, only written entries are ever read.
//  Stalls: the result register frees the input side; a new request is taken
//  while a result waits. The push step holds only while an earlier result
//  is still not taken.
//
module sliding_window_maximum import swm_pkg::*; #(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               window_len_we,
	input  wire logic [WLEN_W-1:0]  window_len,
	swm_sample_if.sink              samples,
	swm_result_if.source            results
);

	localparam int IDX_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int POS_W   = $clog2(2*WINDOW_MAX);
	localparam int POS_MOD = 2*WINDOW_MAX;
	localparam int CNT_W   = $clog2(WINDOW_MAX+1);
	localparam int EFF_W   = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
	localparam int SEEN_CW = (POS_W > EFF_W) ? POS_W : EFF_W;
	localparam int WORD_W  = SAMPLE_W + POS_W;

	// one-hot sequencer
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,	// waiting for a request
		ST_FRONT = 4'b0010,	// drop expired front entries
		ST_REAR  = 4'b0100,	// pop smaller rear entries
		ST_PUSH  = 4'b1000	// write sample, emit result once the window is full
	} state_t;

	state_t                     state_q, state_d;
	logic [WLEN_W-1:0]          window_len_q;
	logic [IDX_W-1:0]           head_q, head_d;
	logic [IDX_W-1:0]           tail_q, tail_d;
	logic [CNT_W-1:0]           count_q, count_d;
	logic [POS_W-1:0]           pos_q, pos_d;
	logic [POS_W-1:0]           seen_q, seen_d;

	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       last_q;
	logic signed [SAMPLE_W-1:0] front_q;

	logic                       res_valid_q;
	logic signed [SAMPLE_W-1:0] res_val_q;
	logic                       res_last_q;

	// RAM and compare unit hookup
	logic                       rd_en;
	logic [IDX_W-1:0]           rd_addr;
	logic [WORD_W-1:0]          rd_word;
	logic                       wr_en;
	logic signed [SAMPLE_W-1:0] rd_val;
	logic [POS_W-1:0]           rd_pos;
	cmp_mode_t                  cmp_mode;
	logic                       cmp_hit;

	logic [EFF_W-1:0]           wl_ext;
	logic [EFF_W-1:0]           eff;
	logic [POS_W-1:0]           seen_inc;
	logic                       produce;
	logic                       req_take;
	logic                       push_go;
	logic [CNT_W-1:0]           ring_occ;

	function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
		idx_next = (i == IDX_W'(WINDOW_MAX-1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
		idx_prev = (i == '0) ? IDX_W'(WINDOW_MAX-1) : i - 1'b1;
	endfunction

	// window length register, clamped to 1..WINDOW_MAX on use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WLEN_RESET;
		end else if (window_len_we) begin
			window_len_q <= window_len;
		end
	end

	assign wl_ext = EFF_W'(window_len_q);

	always_comb begin
		if (wl_ext == '0) begin
			eff = EFF_W'(1);
		end else if (wl_ext > EFF_W'(WINDOW_MAX)) begin
			eff = EFF_W'(WINDOW_MAX);
		end else begin
			eff = wl_ext;
		end
	end

	assign samples.ready = (state_q == ST_IDLE);
	assign req_take      = samples.valid && samples.ready;
	assign push_go       = !res_valid_q || results.ready;

	assign rd_val   = rd_word[POS_W +: SAMPLE_W];
	assign rd_pos   = rd_word[POS_W-1:0];
	assign cmp_mode = (state_q == ST_FRONT) ? CMP_AGE : CMP_VAL;

	// sample count after this one, saturating
	assign seen_inc = (seen_q < POS_W'(POS_MOD-1)) ? seen_q + 1'b1 : seen_q;
	assign produce  = SEEN_CW'(seen_inc) >= SEEN_CW'(eff);
	assign wr_en    = (state_q == ST_PUSH) && push_go;

	swm_ram #(
		.WIDTH (WORD_W),
		.DEPTH (WINDOW_MAX)
	) u_cand_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (tail_q),
		.wdata ({sample_q, pos_q}),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_word)
	);

	swm_cmp #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_cmp (
		.mode   (cmp_mode),
		.pos    (pos_q),
		.rd_pos (rd_pos),
		.eff    (eff),
		.sample (sample_q),
		.rd_val (rd_val),
		.hit    (cmp_hit)
	);

	// sequencer: one candidate read and compare per cycle
	always_comb begin
		state_d = state_q;
		head_d  = head_q;
		tail_d  = tail_q;
		count_d = count_q;
		pos_d   = pos_q;
		seen_d  = seen_q;
		rd_en   = 1'b0;
		rd_addr = head_q;
		case (state_q)
			ST_IDLE: begin
				if (req_take) begin
					if (count_q != '0) begin
						rd_en   = 1'b1;
						rd_addr = head_q;
						state_d = ST_FRONT;
					end else begin
						state_d = ST_PUSH;
					end
				end
			end
			ST_FRONT: begin
				if (cmp_hit) begin
					// front entry left the window
					head_d  = idx_next(head_q);
					count_d = count_q - 1'b1;
					if (count_q != CNT_W'(1)) begin
						rd_en   = 1'b1;
						rd_addr = idx_next(head_q);
					end else begin
						state_d = ST_PUSH;
					end
				end else begin
					rd_en   = 1'b1;
					rd_addr = idx_prev(tail_q);
					state_d = ST_REAR;
				end
			end
			ST_REAR: begin
				if (cmp_hit) begin
					// rear entry can never be the max again
					tail_d  = idx_prev(tail_q);
					count_d = count_q - 1'b1;
					if (count_q != CNT_W'(1)) begin
						rd_en   = 1'b1;
						rd_addr = idx_prev(idx_prev(tail_q));
					end else begin
						state_d = ST_PUSH;
					end
				end else begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (push_go) begin
					state_d = ST_IDLE;
					if (last_q) begin
						head_d  = '0;
						tail_d  = '0;
						count_d = '0;
						pos_d   = '0;
						seen_d  = '0;
					end else begin
						tail_d  = idx_next(tail_q);
						count_d = count_q + 1'b1;
						pos_d   = (pos_q == POS_W'(POS_MOD-1)) ? '0 : pos_q + 1'b1;
						seen_d  = seen_inc;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			pos_q   <= '0;
			seen_q  <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			pos_q   <= pos_d;
			seen_q  <= seen_d;
		end
	end

	// request payload and surviving front value
	always_ff @(posedge clk) begin
		if (req_take) begin
			sample_q <= samples.sample_value;
			last_q   <= samples.last_sample;
		end
		if ((state_q == ST_FRONT) && !cmp_hit) begin
			front_q <= rd_val;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (wr_en) begin
			res_valid_q <= produce;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// empty deque before the push means the new sample is the front
	always_ff @(posedge clk) begin
		if (wr_en && produce) begin
			res_val_q  <= (count_q == '0) ? sample_q : front_q;
			res_last_q <= last_q;
		end
	end

	assign results.valid      = res_valid_q;
	assign results.window_max = res_val_q;
	assign results.is_last    = res_last_q;

	// ring occupancy seen from the pointers
	assign ring_occ = (tail_q >= head_q) ? CNT_W'(tail_q - head_q)
	                                     : CNT_W'(WINDOW_MAX) - CNT_W'(head_q - tail_q);

	// no push into a full deque: the age check keeps room
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (count_q < CNT_W'(WINDOW_MAX)))
		else $error("candidate deque full at push");

	// count agrees with the pointers
	a_ring_count: assert property (@(posedge clk) disable iff (!arst_n)
		(tail_q == head_q) ? ((count_q == '0) || (count_q == CNT_W'(WINDOW_MAX)))
		                   : (count_q == ring_occ))
		else $error("deque count and pointers disagree");

	// a result appears only from the push step
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_PUSH))
		else $error("result raised outside push");

	// a last sample leaves an empty window behind
	a_last_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && last_q) |=> ((count_q == '0) && (pos_q == '0) && (seen_q == '0)))
		else $error("window not cleared after last sample");

	// outside idle the sequencer reads the RAM only while the deque holds entries
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && (state_q != ST_IDLE)) |-> (count_q != '0))
		else $error("candidate read with empty deque");

endmodule
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sliding window maximum. A local deque model
// predicts the result, if any, of every accepted sample request; a checker process
// compares each result taken off the output channel against the oldest
// prediction. Directed cases come first, then random sample streams under
// four idle/stall mixes and a range of window lengths, including lengths
// outside 1..64 and changes in the middle of a sequence.
// ----------------------------------------------------------------------------
module tb_top;
	import swm_pkg::*;

	localparam int WMAX            = WINDOW_MAX_DEF;
	localparam int CYCLE_LIMIT     = 1_000_000;
	// covers the longest single request, with a full expiry and a full pop
	// sweep of the deque, with margin
	localparam int DRAIN_CYCLES    = 160;
	localparam int ITEMS_PER_PHASE = 100;

	localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] wmax;
		logic                       is_last;
	} window_result_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              window_len_we;
	logic [WLEN_W-1:0] window_len;

	swm_sample_if samples_ch ();
	swm_result_if results_ch ();

	sliding_window_maximum #(
		.WINDOW_MAX (WMAX)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.window_len_we (window_len_we),
		.window_len    (window_len),
		.samples       (samples_ch),
		.results       (results_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Deque model: mirrors what the block must hold. Positions count
	// modulo 2*WMAX, which is exactly the 7-bit width, so plain vector
	// subtraction gives the age of an entry.
	// ------------------------------------------------------------------
	logic [WLEN_W-1:0]          wlen_reg;
	logic signed [SAMPLE_W-1:0] cand_val [WMAX];
	logic [WLEN_W-1:0]          cand_pos [WMAX];
	int                         head, tail, cand_count, seen;
	logic [WLEN_W-1:0]          pos_ctr;

	window_result_t expected_maxima [$];

	int fail_count     = 0;
	int cycle_count    = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	// random stream state: samples left in the sequence, value shape, level
	int seq_left  = 0;
	int seq_shape = 0;
	int seq_level = 0;

	// zero acts as one, anything above WMAX acts as WMAX
	function automatic int clamped_len();
		int eff;
		eff = wlen_reg;
		if (eff < 1)
			eff = 1;
		if (eff > WMAX)
			eff = WMAX;
		return eff;
	endfunction

	function automatic void clear_window();
		head       = 0;
		tail       = 0;
		cand_count = 0;
		seen       = 0;
		pos_ctr    = '0;
	endfunction

	function automatic void predict_window(input logic signed [SAMPLE_W-1:0] value,
		input logic last);
		int                eff;
		int                rear;
		logic [WLEN_W-1:0] age;
		eff = clamped_len();
		// expire front entries that fell out of the window
		while (cand_count > 0) begin
			age = pos_ctr - cand_pos[head];
			if (age < eff)
				break;
			head = (head + 1) % WMAX;
			cand_count--;
		end
		// strictly smaller rear entries can never be the max again
		while (cand_count > 0) begin
			rear = (tail == 0) ? WMAX - 1 : tail - 1;
			if (!(value > cand_val[rear]))
				break;
			tail = rear;
			cand_count--;
		end
		if (cand_count >= WMAX) begin
			head = (head + 1) % WMAX;
			cand_count--;
		end
		cand_val[tail] = value;
		cand_pos[tail] = pos_ctr;
		tail           = (tail + 1) % WMAX;
		cand_count++;
		pos_ctr = pos_ctr + 1'b1;
		if (seen < 2 * WMAX - 1)
			seen++;
		if (seen >= eff)
			expected_maxima.push_back('{wmax: cand_val[head], is_last: last});
		if (last)
			clear_window();
	endfunction

	// ------------------------------------------------------------------
	// Request driver. Returns at the edge where the request was taken,
	// with valid still high, so a back-to-back request never lowers and
	// raises valid in the same step.
	// ------------------------------------------------------------------
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			samples_ch.valid <= 1'b0;
			@(posedge clk);
		end
		samples_ch.valid        <= 1'b1;
		samples_ch.sample_value <= value;
		samples_ch.last_sample  <= last;
		@(posedge clk);
		while (!samples_ch.ready)
			@(posedge clk);
		predict_window(value, last);
	endtask

	// Wait until all results are in, then cover a request that gives none.
	task automatic drain_block();
		samples_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_maxima.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_window(input logic [WLEN_W-1:0] len);
		drain_block();
		window_len_we <= 1'b1;
		window_len    <= len;
		@(posedge clk);
		window_len_we <= 1'b0;
		wlen_reg = len;
	endtask

	// ------------------------------------------------------------------
	// Result checker and receiver stall generator
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		window_result_t want;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (expected_maxima.size() == 0) begin
				$display("%0t: unexpected result: window_max %0d is_last %0b", $time,
					results_ch.window_max, results_ch.is_last);
				fail_count++;
			end else begin
				want = expected_maxima.pop_front();
				if (results_ch.window_max !== want.wmax) begin
					$display("%0t: window_max expected %0d actual %0d", $time,
						want.wmax, results_ch.window_max);
					fail_count++;
				end
				if (results_ch.is_last !== want.is_last) begin
					$display("%0t: is_last expected %0b actual %0b", $time,
						want.is_last, results_ch.is_last);
					fail_count++;
				end
			end
		end
		results_ch.ready <= arst_n && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Directed cases
	// ------------------------------------------------------------------

	// window of one: every result is the sample itself, extremes included
	task automatic test_extreme_samples();
		set_window(7'd1);
		send_sample(S_MAX, 1'b0);
		send_sample(S_MIN, 1'b0);
		send_sample(16'sd0, 1'b0);
		send_sample(-16'sd1, 1'b1);
	endtask

	// equal values must stay in the deque; max moves as old peaks expire
	task automatic test_equal_and_order();
		set_window(7'd3);
		send_sample(S_MIN, 1'b0);
		send_sample(S_MAX, 1'b0);
		send_sample(16'sd100, 1'b0);
		send_sample(16'sd100, 1'b0);
		send_sample(16'sd200, 1'b0);
		send_sample(-16'sd5, 1'b1);
	endtask

	// sequence ends before the window fills: no result, state still clears
	task automatic test_early_last();
		set_window(7'd3);
		send_sample(16'sd10, 1'b0);
		send_sample(16'sd20, 1'b1);
	endtask

	// out-of-range lengths: zero acts as one, 127 acts as WMAX
	task automatic test_length_clamp();
		set_window(7'd0);
		send_sample(16'sd3, 1'b0);
		send_sample(-16'sd3, 1'b1);
		set_window(7'd127);
		send_sample(16'sd1, 1'b0);
		send_sample(16'sd2, 1'b1);
	endtask

	// shrink the window mid-sequence: older front entries drop at once
	task automatic test_length_change();
		set_window(7'd4);
		send_sample(16'sd9, 1'b0);
		send_sample(16'sd8, 1'b0);
		send_sample(16'sd7, 1'b0);
		send_sample(16'sd6, 1'b0);
		set_window(7'd2);
		send_sample(16'sd5, 1'b0);
		send_sample(16'sd4, 1'b1);
	endtask

	// ------------------------------------------------------------------
	// Random streams
	// ------------------------------------------------------------------

	// mostly sequences that fill the window, some cut short, some long
	// enough to wrap the position counter and saturate the seen count
	function automatic void start_sequence();
		int eff;
		int r;
		eff = clamped_len();
		r   = $urandom_range(0, 99);
		if (r < 70)
			seq_left = eff + $urandom_range(0, 2 * eff + 4);
		else if (r < 85)
			seq_left = $urandom_range(1, eff);
		else
			seq_left = $urandom_range(130, 260);
		seq_shape = $urandom_range(0, 4);
		seq_level = int'($urandom_range(0, 65535)) - 32768;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] next_sample();
		case (seq_shape)
			0: return SAMPLE_W'($urandom);
			1: begin
				// few distinct values: lots of ties and extremes
				case ($urandom_range(0, 4))
					0: return S_MAX;
					1: return S_MIN;
					2: return 16'sd0;
					3: return -16'sd1;
					default: return 16'sd1;
				endcase
			end
			2: begin
				seq_level += $urandom_range(0, 300);
				if (seq_level > 32767)
					seq_level = 32767;
				return SAMPLE_W'(seq_level);
			end
			3: begin
				seq_level -= $urandom_range(0, 300);
				if (seq_level < -32768)
					seq_level = -32768;
				return SAMPLE_W'(seq_level);
			end
			default: return SAMPLE_W'(seq_level + int'($urandom_range(0, 6)) - 3);
		endcase
	endfunction

	task automatic send_stream(input int count);
		logic signed [SAMPLE_W-1:0] value;
		for (int i = 0; i < count; i++) begin
			if (seq_left == 0)
				start_sequence();
			value = next_sample();
			seq_left--;
			send_sample(value, seq_left == 0);
		end
	endtask

	// first four settings hit the extremes; a sequence left open at the end
	// of a phase carries into the next length
	function automatic logic [WLEN_W-1:0] pick_window(input int idx);
		int r;
		case (idx)
			0: return 7'd1;
			1: return 7'd64;
			2: return 7'd0;
			3: return 7'd127;
			default: begin
				r = $urandom_range(0, 99);
				if (r < 15)
					return WLEN_W'($urandom_range(65, 127));
				else if (r < 30)
					return WLEN_W'($urandom_range(1, 4));
				else
					return WLEN_W'($urandom_range(2, 64));
			end
		endcase
	endfunction

	task automatic test_random_streams();
		int idle_mix  [4] = '{0, 80, 0, 33};
		int stall_mix [4] = '{0, 0, 80, 33};
		for (int m = 0; m < 4; m++) begin
			send_idle_pct  = idle_mix[m];
			recv_stall_pct = stall_mix[m];
			for (int k = 0; k < 4; k++) begin
				set_window(pick_window(m * 4 + k));
				send_stream(ITEMS_PER_PHASE);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence of tests
	// ------------------------------------------------------------------
	initial begin
		arst_n                  = 1'b0;
		window_len_we           = 1'b0;
		window_len              = '0;
		samples_ch.valid        = 1'b0;
		samples_ch.sample_value = '0;
		samples_ch.last_sample  = 1'b0;
		results_ch.ready        = 1'b0;
		wlen_reg                = WLEN_RESET;
		clear_window();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_extreme_samples();
		test_equal_and_order();
		test_early_last();
		test_length_clamp();
		test_length_change();
		test_random_streams();

		drain_block();
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
